// ===== hdl/cct_pkg.sv =====
package cct_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W  = 48;
    localparam int STAMP_W = 32;
    localparam int NUM_W   = 31;
    localparam int TAG_W   = 32;
    localparam int CHAL_W  = 32;
    localparam int LFSR_W  = 32;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 32'hACE1_F00D;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hA300_0000;

    typedef enum logic
    {
        ACT_ISSUE   = 1'b0,
        ACT_CONSUME = 1'b1
    } cct_action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } cct_state_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]  address;
        logic [STAMP_W-1:0] stamp;
        logic [NUM_W-1:0]   number;
        logic [TAG_W-1:0]   version;
    } cct_entry_t;

    // One step of the Galois LFSR (shift right, fold taps on a set low bit)
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] r;
        r = {1'b0, s[LFSR_W-1:1]};
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

// ===== hdl/cct_req_if.sv =====
interface cct_req_if;
    import cct_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [ADDR_W-1:0]  peer_address;
    logic [STAMP_W-1:0] now_ticks;
    logic [TAG_W-1:0]   version_tag;
    logic [CHAL_W-1:0]  challenge_in;

    modport source (output valid, action, peer_address, now_ticks, version_tag, challenge_in,
                    input ready);
    modport sink (input valid, action, peer_address, now_ticks, version_tag, challenge_in,
                  output ready);
endinterface

// ===== hdl/cct_rsp_if.sv =====
interface cct_rsp_if;
    import cct_pkg::*;

    logic             valid;
    logic             ready;
    logic [NUM_W-1:0] challenge_out;
    logic             accepted;
    logic [TAG_W-1:0] version_out;

    modport source (output valid, challenge_out, accepted, version_out, input ready);
    modport sink (input valid, challenge_out, accepted, version_out, output ready);
endinterface

// ===== hdl/connection_challenge_table.sv =====
// A request is answered after the sequencer scans every slot, one slot per cycle,
// then passes the drain and write states; the write state waits while an earlier
// response is held. A new request is taken only when the sequencer is idle again.
// The response register lets the next request be taken while a response waits.
// Reset (rst_n, asynchronous, active low) clears all slot valid flags, loads the
// LFSR seed and idles the sequencer; slot contents stay as they are.
module connection_challenge_table
(
    input  logic      clk,
    input  logic      rst_n,
    cct_req_if.sink   req,
    cct_rsp_if.source rsp
);
    import cct_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    // Slot storage: payload in a memory, valid flags in flip-flops
    cct_entry_t slot_mem [SLOTS];
    logic       slot_valid_reg [SLOTS];

    cct_state_t state_reg, state_next;

    // Latched request word
    cct_action_t        action_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [STAMP_W-1:0] now_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [CHAL_W-1:0]  chal_in_reg;

    // Scan address and the check stage behind the memory read
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic              chk_en_reg, chk_en_next;
    logic [SLOT_W-1:0] chk_idx_reg;
    logic              chk_vld_reg;
    cct_entry_t        rd_entry_reg;

    // Scan findings
    logic               hit_reg, hit_next;
    logic [SLOT_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [NUM_W-1:0]   hit_num_reg, hit_num_next;
    logic [TAG_W-1:0]   hit_ver_reg, hit_ver_next;
    logic               free_reg, free_next;
    logic [SLOT_W-1:0]  free_idx_reg, free_idx_next;
    logic               old_reg, old_next;
    logic [SLOT_W-1:0]  old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0] old_stamp_reg, old_stamp_next;

    logic [LFSR_W-1:0]  lfsr_reg, lfsr_next;

    // Response register
    logic               out_valid_reg, out_valid_next;
    logic [NUM_W-1:0]   out_chal_reg, out_chal_next;
    logic               out_acc_reg, out_acc_next;
    logic [TAG_W-1:0]   out_ver_reg, out_ver_next;

    // Control from the output decode
    logic              take;
    logic              go;
    logic              mem_we;
    logic [SLOT_W-1:0] wr_idx;
    cct_entry_t        wr_entry;
    logic              vld_we;
    logic              vld_val;

    logic              chk_match;
    logic              num_match;
    logic [LFSR_W-1:0] lfsr_adv;

    assign take      = req.valid && req.ready;
    assign go        = !out_valid_reg || rsp.ready;
    assign chk_match = chk_vld_reg && (rd_entry_reg.address == addr_reg);
    assign num_match = (chal_in_reg == {1'b0, hit_num_reg});
    assign lfsr_adv  = lfsr_step(lfsr_reg);

    assign rsp.valid         = out_valid_reg;
    assign rsp.challenge_out = out_chal_reg;
    assign rsp.accepted      = out_acc_reg;
    assign rsp.version_out   = out_ver_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == SLOT_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake and table writes
    always_comb
    begin
        req.ready = 1'b0;
        mem_we    = 1'b0;
        vld_we    = 1'b0;
        vld_val   = 1'b0;
        wr_idx    = hit_idx_reg;
        wr_entry  = '{address: addr_reg, stamp: now_reg, number: hit_num_reg, version: tag_reg};
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_WRITE:
            begin
                if (go)
                begin
                    if (action_reg == ACT_ISSUE)
                    begin
                        mem_we  = 1'b1;
                        vld_we  = 1'b1;
                        vld_val = 1'b1;
                        if (!hit_reg)
                        begin
                            wr_idx          = free_reg ? free_idx_reg : old_idx_reg;
                            wr_entry.number = lfsr_adv[NUM_W-1:0];
                        end
                    end
                    else if (hit_reg && num_match)
                    begin
                        // release: drop the valid flag, contents become dead
                        vld_we  = 1'b1;
                        vld_val = 1'b0;
                    end
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        chk_en_next    = (state_reg == ST_SCAN);
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_num_next   = hit_num_reg;
        hit_ver_next   = hit_ver_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        old_next       = old_reg;
        old_idx_next   = old_idx_reg;
        old_stamp_next = old_stamp_reg;
        lfsr_next      = lfsr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_chal_next  = out_chal_reg;
        out_acc_next   = out_acc_reg;
        out_ver_next   = out_ver_reg;

        if (take)
        begin
            scan_idx_next = '0;
            hit_next      = 1'b0;
            free_next     = 1'b0;
            old_next      = 1'b0;
        end
        else if (state_reg == ST_SCAN && scan_idx_reg != SLOT_LAST)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // Check stage: first live match, first free slot, oldest live slot
        if (chk_en_reg)
        begin
            if (chk_match && !hit_reg)
            begin
                hit_next     = 1'b1;
                hit_idx_next = chk_idx_reg;
                hit_num_next = rd_entry_reg.number;
                hit_ver_next = rd_entry_reg.version;
            end
            if (!chk_vld_reg && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = chk_idx_reg;
            end
            if (chk_vld_reg && (!old_reg || rd_entry_reg.stamp < old_stamp_reg))
            begin
                old_next       = 1'b1;
                old_idx_next   = chk_idx_reg;
                old_stamp_next = rd_entry_reg.stamp;
            end
        end

        if (state_reg == ST_WRITE && go)
        begin
            out_valid_next = 1'b1;
            out_chal_next  = '0;
            out_acc_next   = 1'b0;
            out_ver_next   = '0;
            if (action_reg == ACT_ISSUE)
            begin
                out_chal_next = wr_entry.number;
                if (!hit_reg)
                begin
                    lfsr_next = lfsr_adv;
                end
            end
            else if (hit_reg && num_match)
            begin
                out_acc_next = 1'b1;
                out_ver_next = hit_ver_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chk_en_reg    <= chk_en_next;
            out_valid_reg <= out_valid_next;
            lfsr_reg      <= lfsr_next;
            if (vld_we)
            begin
                slot_valid_reg[wr_idx] <= vld_val;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            action_reg  <= cct_action_t'(req.action);
            addr_reg    <= req.peer_address;
            now_reg     <= req.now_ticks;
            tag_reg     <= req.version_tag;
            chal_in_reg <= req.challenge_in;
        end
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= scan_idx_reg;
        chk_vld_reg    <= slot_valid_reg[scan_idx_reg];
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_num_reg    <= hit_num_next;
        hit_ver_reg    <= hit_ver_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        old_reg        <= old_next;
        old_idx_reg    <= old_idx_next;
        old_stamp_reg  <= old_stamp_next;
        out_chal_reg   <= out_chal_next;
        out_acc_reg    <= out_acc_next;
        out_ver_reg    <= out_ver_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= slot_mem[scan_idx_reg];
    end

    // Hold off new requests for the whole scan
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !req.ready)
        else $error("request taken while a scan is running");

    // LFSR never collapses to the all-zero lock-up state
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("LFSR reached zero");

    // A released slot answers with its tag and no number
    a_accept_no_number: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> (rsp.challenge_out == '0))
        else $error("accepted consume carries a challenge number");

    // Tag leaves the block only on an accepted consume
    a_tag_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.accepted) |-> (rsp.version_out == '0))
        else $error("version tag returned without an accepted consume");

endmodule
